### hdl/matrix_multiply_engine_macros.svh
// Assertion macros shared by the engine's modules.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define MME_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define MME_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`define MME_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

`else

`define MME_ASSERT_IMPL(name, clk, rst_n, ante, cons)

`define MME_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`define MME_ASSERT_ALWAYS(name, clk, rst_n, cond)

`endif

`endif

### hdl/mme_pkg.sv
package mme_pkg;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 4;   // row/column fields and loop counters
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 36;
    localparam int DIM_W   = 5;   // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_CALC_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } mme_state_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             start;
        logic             issue;
        logic             first;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] j;
        logic             capture;
        logic             last;
    } mme_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic slot_free;
    } mme_status_t;

endpackage

### hdl/mme_if.sv
interface mme_req_if;
    import mme_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] elem_value;

    modport source (output valid, output func, output row_index, output col_index,
                    output elem_value, input ready);
    modport sink (input valid, input func, input row_index, input col_index,
                  input elem_value, output ready);
endinterface

interface mme_rsp_if;
    import mme_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_col;
    logic signed [ACC_W-1:0] out_value;
    logic                    last;

    modport source (output valid, output out_col, output out_value, output last,
                    input ready);
    modport sink (input valid, input out_col, input out_value, input last,
                  output ready);
endinterface

### hdl/mme_ctrl.sv
`include "matrix_multiply_engine_macros.svh"

module mme_ctrl #(
    parameter int MAX_DIM = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]       cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [mme_pkg::FUNC_W-1:0]      req_func,
    input  logic [mme_pkg::IDX_W-1:0]       req_row,
    input  logic [mme_pkg::IDX_W-1:0]       req_col,
    input  mme_pkg::mme_status_t            status,
    output mme_pkg::mme_cmd_t               cmd
);
    import mme_pkg::*;

    localparam int DIM_LIMIT = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam int RANGE_W   = 8;

    mme_state_t       state_reg, state_next;
    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] nr, nk, nc;
    logic             accept;
    logic             in_store;
    logic             row_ok;
    logic             k_last;
    logic             j_last;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(DIM_LIMIT))
            r = DIM_W'(DIM_LIMIT);
        else
            r = v;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign nr = eff_dim(rows_a_reg);
    assign nk = eff_dim(inner_dim_reg);
    assign nc = eff_dim(cols_b_reg);

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    // drop loads that fall outside the physical store
    assign in_store  = (RANGE_W'(req_row) < RANGE_W'(MAX_DIM))
                    && (RANGE_W'(req_col) < RANGE_W'(MAX_DIM));
    assign row_ok    = DIM_W'(req_row) < nr;
    assign k_last    = (DIM_W'(k_reg) + DIM_W'(1)) == nk;
    assign j_last    = (DIM_W'(j_reg) + DIM_W'(1)) == nc;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_func == FUNC_COMPUTE && row_ok)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (k_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy && status.slot_free)
                    state_next = j_last ? ST_IDLE : ST_ISSUE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.k       = k_reg;
        cmd.j       = j_reg;
        cmd.first   = (k_reg == '0);
        cmd.last    = j_last;
        k_next      = k_reg;
        j_next      = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_a  = accept && req_func == FUNC_WRITE_A && in_store;
                cmd.wr_b  = accept && req_func == FUNC_WRITE_B && in_store;
                cmd.start = accept && req_func == FUNC_COMPUTE && row_ok;
                k_next    = '0;
                j_next    = '0;
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                k_next    = k_last ? '0 : k_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                cmd.capture = !status.pipe_busy && status.slot_free;
                if (cmd.capture)
                    j_next = j_reg + IDX_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

    `MME_ASSERT_NEXT(a_last_col_to_idle, clk, rst_n, cmd.capture && cmd.last, state_reg == ST_IDLE)
    `MME_ASSERT_IMPL(a_issue_col_in_range, clk, rst_n, cmd.issue, DIM_W'(j_reg) < nc)
    `MME_ASSERT_IMPL(a_no_accept_when_busy, clk, rst_n, state_reg != ST_IDLE, !cmd.wr_a && !cmd.wr_b && !cmd.start)

endmodule

### hdl/mme_dp.sv
`include "matrix_multiply_engine_macros.svh"

module mme_dp #(
    parameter int MAX_DIM = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mme_pkg::mme_cmd_t                cmd,
    output mme_pkg::mme_status_t             status,
    input  logic [mme_pkg::IDX_W-1:0]        req_row,
    input  logic [mme_pkg::IDX_W-1:0]        req_col,
    input  logic signed [mme_pkg::ELEM_W-1:0] req_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mme_pkg::IDX_W-1:0]        out_col,
    output logic signed [mme_pkg::ACC_W-1:0] out_value,
    output logic                             out_last
);
    import mme_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    logic signed [ELEM_W-1:0] mem_a [0:DEPTH-1];
    logic signed [ELEM_W-1:0] mem_b [0:DEPTH-1];

    logic [IDX_W-1:0]         row_reg;
    logic [ADDR_CALC_W-1:0]   waddr_wide, raddr_a_wide, raddr_b_wide;
    logic [ADDR_W-1:0]        waddr, raddr_a, raddr_b;
    logic signed [ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic                     rd_valid_reg;
    logic                     first1_reg, first2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [ACC_W-1:0]  out_value_reg;
    logic                     out_last_reg;

    assign waddr_wide   = ADDR_CALC_W'(req_row) * ADDR_CALC_W'(MAX_DIM) + ADDR_CALC_W'(req_col);
    assign raddr_a_wide = ADDR_CALC_W'(row_reg) * ADDR_CALC_W'(MAX_DIM) + ADDR_CALC_W'(cmd.k);
    assign raddr_b_wide = ADDR_CALC_W'(cmd.k) * ADDR_CALC_W'(MAX_DIM) + ADDR_CALC_W'(cmd.j);
    assign waddr   = waddr_wide[ADDR_W-1:0];
    assign raddr_a = raddr_a_wide[ADDR_W-1:0];
    assign raddr_b = raddr_b_wide[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            mem_a[waddr] <= req_value;
        if (cmd.issue)
            a_rd_reg <= mem_a[raddr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
            mem_b[waddr] <= req_value;
        if (cmd.issue)
            b_rd_reg <= mem_b[raddr_b];
    end

    // payload pipeline: row latch, first-flag delay, product, accumulator, output capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            row_reg <= req_row;
        first1_reg <= cmd.first;
        first2_reg <= first1_reg;
        prod_reg   <= a_rd_reg * b_rd_reg;
        if (prod_valid_reg)
            acc_reg <= first2_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        if (cmd.capture)
        begin
            out_col_reg   <= cmd.j;
            out_value_reg <= acc_reg;
            out_last_reg  <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.issue;
            prod_valid_reg <= rd_valid_reg;
            if (cmd.capture)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.pipe_busy = rd_valid_reg || prod_valid_reg;
    assign status.slot_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    `MME_ASSERT_IMPL(a_capture_when_drained, clk, rst_n, cmd.capture, !rd_valid_reg && !prod_valid_reg && (!out_valid_reg || out_ready))
    `MME_ASSERT_IMPL(a_prod_follows_read, clk, rst_n, prod_valid_reg, $past(rd_valid_reg))
    `MME_ASSERT_ALWAYS(a_one_command, clk, rst_n, $onehot0({cmd.wr_a, cmd.wr_b, cmd.start, cmd.issue, cmd.capture}))

endmodule

### hdl/matrix_multiply_engine.sv
// Loads (write A or B element) leave the engine idle, so the next request is taken the next cycle.
// A row request runs cols_b columns: one shared MAC walks inner_dim
// products per column through a registered store read and a product register, then drains.
// Each result sits in an output register, so a new request is taken while it waits.
// Reset (rst_n, async, active low) sets all three dimensions to 16 and empties the pipeline;
// the A and B stores are not cleared and hold unknown data until written.
module matrix_multiply_engine #(
    parameter int MAX_DIM = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]     cfg_data,
    mme_req_if.sink                       req,
    mme_rsp_if.source                     rsp
);
    import mme_pkg::*;

    mme_cmd_t    cmd;
    mme_status_t status;

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_func  (req.func),
        .req_row   (req.row_index),
        .req_col   (req.col_index),
        .status    (status),
        .cmd       (cmd)
    );

    mme_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_row   (req.row_index),
        .req_col   (req.col_index),
        .req_value (req.elem_value),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_col   (rsp.out_col),
        .out_value (rsp.out_value),
        .out_last  (rsp.last)
    );

endmodule
